// ----- hdl/tdsc_pkg.sv -----
package tdsc_pkg;

    // dimension and queue sizing
    localparam int MAX_RANK = 4;
    localparam int NUM_DIMS = 4;
    localparam int NUM_MULS = NUM_DIMS - 1;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // register indexes
    localparam logic [1:0] REG_HEADER_END = 2'd0;
    localparam logic [1:0] REG_ALIGN      = 2'd1;
    localparam logic [1:0] REG_TOTAL      = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RANK       = 4'd1;
    localparam logic [3:0] ST_SHAPE      = 4'd2;
    localparam logic [3:0] ST_TYPE       = 4'd3;
    localparam logic [3:0] ST_DIV        = 4'd4;
    localparam logic [3:0] ST_BYTES      = 4'd5;
    localparam logic [3:0] ST_ALIGN_ZERO = 4'd6;
    localparam logic [3:0] ST_ALIGN_OVF  = 4'd7;
    localparam logic [3:0] ST_START_END  = 4'd8;
    localparam logic [3:0] ST_OFF_END    = 4'd9;
    localparam logic [3:0] ST_RANGE_END  = 4'd10;

    typedef struct packed {
        logic [3:0]  rank;
        logic [63:0] dim_a;
        logic [63:0] dim_b;
        logic [63:0] dim_c;
        logic [63:0] dim_d;
        logic [31:0] type_code;
        logic [63:0] rel_offset;
    } desc_t;

    typedef struct packed {
        logic [63:0] byte_count;
        logic [63:0] abs_offset;
        logic [3:0]  status;
    } res_t;

    // data section values derived from the registers
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] room;
        logic        align_zero;
        logic        align_ovf;
        logic        start_past;
    } cfg_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] shift;
        logic [8:0] bpb;
    } layout_t;

    // classified item between front and back
    typedef struct packed {
        logic [NUM_DIMS-1:0][63:0] dims;
        logic                      rank_bad;
        logic                      type_bad;
        logic [3:0]                shift;
        logic [8:0]                bpb;
        logic [3:0]                cfg_code;
        logic [63:0]               abs_off;
        logic [63:0]               rest;
    } item_t;

    // block size as a shift and bytes per block for each type code
    function automatic layout_t type_layout(input logic [31:0] code);
        layout_t lay;
        lay = '{ok: 1'b1, shift: 4'd0, bpb: 9'd0};
        case (code)
            32'd0:  lay.bpb = 9'd4;
            32'd1:  lay.bpb = 9'd2;
            32'd2:  begin lay.shift = 4'd5; lay.bpb = 9'd18;  end
            32'd3:  begin lay.shift = 4'd5; lay.bpb = 9'd20;  end
            32'd6:  begin lay.shift = 4'd5; lay.bpb = 9'd22;  end
            32'd7:  begin lay.shift = 4'd5; lay.bpb = 9'd24;  end
            32'd8:  begin lay.shift = 4'd5; lay.bpb = 9'd34;  end
            32'd9:  begin lay.shift = 4'd5; lay.bpb = 9'd36;  end
            32'd10: begin lay.shift = 4'd8; lay.bpb = 9'd84;  end
            32'd11: begin lay.shift = 4'd8; lay.bpb = 9'd110; end
            32'd12: begin lay.shift = 4'd8; lay.bpb = 9'd144; end
            32'd13: begin lay.shift = 4'd8; lay.bpb = 9'd176; end
            32'd14: begin lay.shift = 4'd8; lay.bpb = 9'd210; end
            32'd15: begin lay.shift = 4'd8; lay.bpb = 9'd292; end
            32'd16: begin lay.shift = 4'd8; lay.bpb = 9'd66;  end
            32'd17: begin lay.shift = 4'd8; lay.bpb = 9'd74;  end
            32'd18: begin lay.shift = 4'd8; lay.bpb = 9'd98;  end
            32'd19: begin lay.shift = 4'd8; lay.bpb = 9'd50;  end
            32'd20: begin lay.shift = 4'd5; lay.bpb = 9'd18;  end
            32'd21: begin lay.shift = 4'd8; lay.bpb = 9'd110; end
            32'd22: begin lay.shift = 4'd8; lay.bpb = 9'd82;  end
            32'd23: begin lay.shift = 4'd8; lay.bpb = 9'd136; end
            32'd24: lay.bpb = 9'd1;
            32'd25: lay.bpb = 9'd2;
            32'd26: lay.bpb = 9'd4;
            32'd27: lay.bpb = 9'd8;
            32'd28: lay.bpb = 9'd8;
            32'd29: begin lay.shift = 4'd8; lay.bpb = 9'd56;  end
            32'd30: lay.bpb = 9'd2;
            32'd34: begin lay.shift = 4'd8; lay.bpb = 9'd54;  end
            32'd35: begin lay.shift = 4'd8; lay.bpb = 9'd66;  end
            32'd39: begin lay.shift = 4'd5; lay.bpb = 9'd17;  end
            32'd40: begin lay.shift = 4'd6; lay.bpb = 9'd36;  end
            32'd41: begin lay.shift = 4'd7; lay.bpb = 9'd18;  end
            default: lay.ok = 1'b0;
        endcase
        return lay;
    endfunction

endpackage

// ----- hdl/tdsc_cfg.sv -----
module tdsc_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_wdata,
    output tdsc_pkg::cfg_t   cfg,
    output logic             busy
);
    import tdsc_pkg::*;

    typedef enum logic [3:0] {
        CS_IDLE = 4'b0001,
        CS_DIV  = 4'b0010,
        CS_ADD  = 4'b0100,
        CS_CMP  = 4'b1000
    } cstate_t;

    cstate_t     state_reg;
    logic [63:0] header_end_reg;
    logic [31:0] align_reg;
    logic [63:0] total_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] start_reg;
    logic [63:0] room_reg;
    logic        align_zero_reg;
    logic        align_ovf_reg;
    logic        start_past_reg;

    logic [32:0] trial;
    logic [31:0] rem_next;
    logic [31:0] delta;
    logic [64:0] start_sum;
    logic [64:0] room_diff;

    // one quotient bit per cycle, msb first
    always_comb
    begin
        trial     = {rem_reg, header_end_reg[cnt_reg]};
        rem_next  = (trial >= {1'b0, align_reg}) ? 32'(trial - {1'b0, align_reg})
                                                 : trial[31:0];
        delta     = align_reg - rem_reg;
        start_sum = {1'b0, header_end_reg} + {33'd0, delta};
        room_diff = {1'b0, total_reg} - {1'b0, start_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CS_IDLE;
            header_end_reg <= 64'd0;
            align_reg      <= 32'd32;
            total_reg      <= 64'd0;
            cnt_reg        <= '0;
            rem_reg        <= '0;
            start_reg      <= 64'd0;
            room_reg       <= 64'd0;
            align_zero_reg <= 1'b0;
            align_ovf_reg  <= 1'b0;
            start_past_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_END: header_end_reg <= cfg_wdata;
                REG_ALIGN:      align_reg      <= cfg_wdata[31:0];
                REG_TOTAL:      total_reg      <= cfg_wdata;
                default:        ;
            endcase
            state_reg <= CS_DIV;
            cnt_reg   <= '1;
            rem_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                CS_DIV:
                begin
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= CS_ADD;
                    end
                end
                CS_ADD:
                begin
                    align_zero_reg <= (align_reg == 32'd0);
                    if (rem_reg == 32'd0)
                    begin
                        start_reg     <= header_end_reg;
                        align_ovf_reg <= 1'b0;
                    end
                    else
                    begin
                        start_reg     <= start_sum[63:0];
                        align_ovf_reg <= start_sum[64];
                    end
                    state_reg <= CS_CMP;
                end
                CS_CMP:
                begin
                    start_past_reg <= room_diff[64];
                    room_reg       <= room_diff[63:0];
                    state_reg      <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != CS_IDLE);
    assign cfg.start      = start_reg;
    assign cfg.room       = room_reg;
    assign cfg.align_zero = align_zero_reg;
    assign cfg.align_ovf  = align_ovf_reg;
    assign cfg.start_past = start_past_reg;

endmodule

// ----- hdl/tdsc_front.sv -----
module tdsc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    output logic             desc_stall,
    input  tdsc_pkg::desc_t  desc,
    input  tdsc_pkg::cfg_t   cfg,
    input  logic             cfg_busy,
    input  logic             cfg_we,
    input  logic             q_full,
    output logic             push,
    output tdsc_pkg::item_t  item
);
    import tdsc_pkg::*;

    logic    f_valid_reg;
    item_t   f_item_reg;
    item_t   f_item_next;
    layout_t lay;
    logic    take;
    logic [64:0] off_diff;

    assign push       = f_valid_reg && !q_full;
    assign desc_stall = cfg_busy || cfg_we || (f_valid_reg && q_full);
    assign take       = desc_valid && !desc_stall;
    assign item       = f_item_reg;

    always_comb
    begin
        lay      = type_layout(desc.type_code);
        off_diff = {1'b0, cfg.room} - {1'b0, desc.rel_offset};

        // unused dimensions enter the product as one
        f_item_next.dims[0] = desc.dim_a;
        f_item_next.dims[1] = (desc.rank >= 4'd2) ? desc.dim_b : 64'd1;
        f_item_next.dims[2] = (desc.rank >= 4'd3) ? desc.dim_c : 64'd1;
        f_item_next.dims[3] = (desc.rank >= 4'd4) ? desc.dim_d : 64'd1;
        f_item_next.rank_bad = (desc.rank == 4'd0) || (desc.rank > 4'(MAX_RANK))
                               || (desc.rank > 4'(NUM_DIMS));
        f_item_next.type_bad = !lay.ok;
        f_item_next.shift    = lay.shift;
        f_item_next.bpb      = lay.bpb;
        f_item_next.abs_off  = cfg.start + desc.rel_offset;
        f_item_next.rest     = off_diff[63:0];

        priority if (cfg.align_zero)
            f_item_next.cfg_code = ST_ALIGN_ZERO;
        else if (cfg.align_ovf)
            f_item_next.cfg_code = ST_ALIGN_OVF;
        else if (cfg.start_past)
            f_item_next.cfg_code = ST_START_END;
        else if (off_diff[64])
            f_item_next.cfg_code = ST_OFF_END;
        else
            f_item_next.cfg_code = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

// ----- hdl/tdsc_queue.sv -----
module tdsc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tdsc_pkg::item_t  push_item,
    input  logic             pop,
    output logic             q_valid,
    output tdsc_pkg::item_t  q_item,
    output logic             full
);
    import tdsc_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_valid = (count_reg != '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/tdsc_back.sv -----
module tdsc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tdsc_pkg::item_t  q_item,
    output logic             pop,
    output logic             res_valid,
    input  logic             res_stall,
    output tdsc_pkg::res_t   res
);
    import tdsc_pkg::*;

    logic adv;

    // per multiplier source
    logic        src_v   [NUM_MULS];
    item_t       src_item[NUM_MULS];
    logic [63:0] src_acc [NUM_MULS];
    logic        src_ovf [NUM_MULS];
    logic [63:0] ll_w    [NUM_MULS];
    logic [63:0] lh_w    [NUM_MULS];
    logic [63:0] hl_w    [NUM_MULS];
    logic        both_w  [NUM_MULS];
    logic [64:0] sum_w   [NUM_MULS];

    // partial products
    logic        a_v_reg   [NUM_MULS];
    item_t       a_item_reg[NUM_MULS];
    logic        a_ovf_reg [NUM_MULS];
    logic        a_both_reg[NUM_MULS];
    logic [63:0] a_ll_reg  [NUM_MULS];
    logic [63:0] a_lh_reg  [NUM_MULS];
    logic [63:0] a_hl_reg  [NUM_MULS];
    // middle sum
    logic        b_v_reg   [NUM_MULS];
    item_t       b_item_reg[NUM_MULS];
    logic        b_ovf_reg [NUM_MULS];
    logic [63:0] b_ll_reg  [NUM_MULS];
    logic [64:0] b_mid_reg [NUM_MULS];
    // running product
    logic        c_v_reg   [NUM_MULS];
    item_t       c_item_reg[NUM_MULS];
    logic        c_ovf_reg [NUM_MULS];
    logic [63:0] c_acc_reg [NUM_MULS];

    // block split and byte product
    logic        d_v_reg;
    item_t       d_item_reg;
    logic        d_shape_reg;
    logic        d_div_reg;
    logic [72:0] d_prod_reg;
    logic [63:0] mask_w;
    logic [63:0] blocks_w;
    logic [72:0] prod_w;

    logic        out_valid_reg;
    res_t        out_reg;
    res_t        out_next;
    logic [63:0] bytes_w;

    assign adv       = !out_valid_reg || !res_stall;
    assign pop       = adv && q_valid;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_MULS; k++)
        begin
            if (k == 0)
            begin
                src_v[k]    = q_valid;
                src_item[k] = q_item;
                src_acc[k]  = q_item.dims[0];
                src_ovf[k]  = 1'b0;
            end
            else
            begin
                src_v[k]    = c_v_reg[k-1];
                src_item[k] = c_item_reg[k-1];
                src_acc[k]  = c_acc_reg[k-1];
                src_ovf[k]  = c_ovf_reg[k-1];
            end
            ll_w[k]   = src_acc[k][31:0]  * src_item[k].dims[k+1][31:0];
            lh_w[k]   = src_acc[k][31:0]  * src_item[k].dims[k+1][63:32];
            hl_w[k]   = src_acc[k][63:32] * src_item[k].dims[k+1][31:0];
            both_w[k] = (src_acc[k][63:32] != 32'd0)
                        && (src_item[k].dims[k+1][63:32] != 32'd0);
            sum_w[k]  = {1'b0, b_ll_reg[k]} + {1'b0, b_mid_reg[k][31:0], 32'd0};
        end
    end

    always_comb
    begin
        mask_w   = (64'd1 << c_item_reg[NUM_MULS-1].shift) - 64'd1;
        blocks_w = c_acc_reg[NUM_MULS-1] >> c_item_reg[NUM_MULS-1].shift;
        prod_w   = {9'd0, blocks_w} * {64'd0, c_item_reg[NUM_MULS-1].bpb};
    end

    always_comb
    begin
        bytes_w = d_prod_reg[63:0];
        out_next.byte_count = 64'd0;
        out_next.abs_offset = 64'd0;
        priority if (d_item_reg.rank_bad)
            out_next.status = ST_RANK;
        else if (d_shape_reg)
            out_next.status = ST_SHAPE;
        else if (d_item_reg.type_bad)
            out_next.status = ST_TYPE;
        else if (d_div_reg)
            out_next.status = ST_DIV;
        else if (d_prod_reg[72:64] != 9'd0)
            out_next.status = ST_BYTES;
        else if (d_item_reg.cfg_code != ST_OK)
            out_next.status = d_item_reg.cfg_code;
        else if ((bytes_w != 64'd0) && (bytes_w > d_item_reg.rest))
            out_next.status = ST_RANGE_END;
        else
        begin
            out_next.status     = ST_OK;
            out_next.byte_count = bytes_w;
            out_next.abs_offset = d_item_reg.abs_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_MULS; k++)
            begin
                a_v_reg[k] <= 1'b0;
                b_v_reg[k] <= 1'b0;
                c_v_reg[k] <= 1'b0;
            end
            d_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < NUM_MULS; k++)
            begin
                a_v_reg[k] <= src_v[k];
                b_v_reg[k] <= a_v_reg[k];
                c_v_reg[k] <= b_v_reg[k];
            end
            d_v_reg       <= c_v_reg[NUM_MULS-1];
            out_valid_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_MULS; k++)
            begin
                a_item_reg[k] <= src_item[k];
                a_ovf_reg[k]  <= src_ovf[k];
                a_both_reg[k] <= both_w[k];
                a_ll_reg[k]   <= ll_w[k];
                a_lh_reg[k]   <= lh_w[k];
                a_hl_reg[k]   <= hl_w[k];

                b_item_reg[k] <= a_item_reg[k];
                b_ovf_reg[k]  <= a_ovf_reg[k] || a_both_reg[k];
                b_ll_reg[k]   <= a_ll_reg[k];
                b_mid_reg[k]  <= {1'b0, a_lh_reg[k]} + {1'b0, a_hl_reg[k]};

                c_item_reg[k] <= b_item_reg[k];
                c_ovf_reg[k]  <= b_ovf_reg[k] || (b_mid_reg[k][64:32] != 33'd0)
                                 || sum_w[k][64];
                c_acc_reg[k]  <= sum_w[k][63:0];
            end
            d_item_reg  <= c_item_reg[NUM_MULS-1];
            d_shape_reg <= c_ovf_reg[NUM_MULS-1];
            d_div_reg   <= (c_acc_reg[NUM_MULS-1] & mask_w) != 64'd0;
            d_prod_reg  <= prod_w;
            out_reg     <= out_next;
        end
    end

endmodule

// ----- hdl/tensor_descriptor_size_checker.sv -----
// tensor descriptor size checker
// desc channel: one descriptor per item (rank, four dimensions, type code,
// offset relative to the data section); accepted when desc_valid is high and
// desc_stall is low
// res channel: one result per descriptor, in order: byte count, absolute
// offset and status; taken when res_valid is high and res_stall is low
// config port: cfg_we writes cfg_wdata into the register at cfg_index
// (0 header end, 1 alignment, 2 total size, 3 ignored)
// path: front register, queue, multiplier chain, block split, result register
// throughput: one item per cycle, set by the fully pipelined multiplier chain,
// while res_stall and desc_stall are low; a register write starts a bit-serial
// remainder unit that recomputes the data section start; desc_stall stays high until it ends
// a four-entry queue separates the classifying front from the arithmetic back,
// so the front keeps taking items for a while when res_stall is high; once the
// queue is full and the front register holds an item desc_stall rises
// reset: empties all stages, header end 0, alignment 32, total size 0
module tensor_descriptor_size_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    output logic             desc_stall,
    input  tdsc_pkg::desc_t  desc,
    output logic             res_valid,
    input  logic             res_stall,
    output tdsc_pkg::res_t   res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_wdata
);
    import tdsc_pkg::*;

    cfg_t  cfg;
    logic  cfg_busy;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_valid;
    item_t q_item;
    logic  q_full;

    // register file and data section start
    tdsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .busy      (cfg_busy)
    );

    // rank and type checks, offset range checks
    tdsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc       (desc),
        .cfg        (cfg),
        .cfg_busy   (cfg_busy),
        .cfg_we     (cfg_we),
        .q_full     (q_full),
        .push       (push),
        .item       (push_item)
    );

    tdsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .full      (q_full)
    );

    // shape product, block split, byte count, final status
    tdsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ----- hdl/tdsc_checker.sv -----
module tdsc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             desc_stall,
    input logic             res_valid,
    input logic             res_stall,
    input tdsc_pkg::res_t   res,
    input logic             cfg_we
);
    import tdsc_pkg::*;

    // a waiting result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.status <= ST_RANGE_END)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_OK |-> res.byte_count == 64'd0
                                            && res.abs_offset == 64'd0)
        else $error("error result carries nonzero fields");

    // no item taken while a register is written or as the start recompute begins
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> desc_stall ##1 desc_stall)
        else $error("item taken during configuration");

endmodule

bind tensor_descriptor_size_checker tdsc_checker u_tdsc_checker (.*);
